FILE: rtl/core/tun_pkg.sv
// ----------------------------------------------------------------------------
// tun_pkg
// Types and widths shared by the triangle unit normal core.
// ----------------------------------------------------------------------------
package tun_pkg;

	localparam int COORD_W  = 16;
	localparam int FRAC_W   = 15;
	localparam int NORM_W   = FRAC_W + 1;
	localparam int EDGE_W   = COORD_W + 1;
	localparam int PROD_W   = 2 * EDGE_W;
	localparam int CROSS_W  = PROD_W + 1;
	localparam int MAG_W    = PROD_W;
	localparam int SQ_W     = 2 * MAG_W;
	localparam int SUM_W    = SQ_W + 2;
	// root w = floor(m * 2^(F+1) / |c|) fits in F+2 bits
	localparam int ROOT_W   = FRAC_W + 2;
	localparam int SCALE_SH = 2 * FRAC_W + 2;
	localparam int RW       = 2 * ROOT_W + SUM_W + 1;

	typedef struct packed {
		logic signed [COORD_W-1:0] first_x;
		logic signed [COORD_W-1:0] first_y;
		logic signed [COORD_W-1:0] first_z;
		logic signed [COORD_W-1:0] second_x;
		logic signed [COORD_W-1:0] second_y;
		logic signed [COORD_W-1:0] second_z;
		logic signed [COORD_W-1:0] third_x;
		logic signed [COORD_W-1:0] third_y;
		logic signed [COORD_W-1:0] third_z;
	} tri_in_t;

	typedef struct packed {
		logic signed [NORM_W-1:0] normal_x;
		logic signed [NORM_W-1:0] normal_y;
		logic signed [NORM_W-1:0] normal_z;
		logic                     degenerate;
	} tri_out_t;

endpackage

FILE: rtl/core/tun_in_if.sv
// ----------------------------------------------------------------------------
// tun_in_if
// Triangle input channel: valid/ready with three vertices.
// ----------------------------------------------------------------------------
interface tun_in_if;
	logic             valid;
	logic             ready;
	tun_pkg::tri_in_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

FILE: rtl/core/tun_out_if.sv
// ----------------------------------------------------------------------------
// tun_out_if
// Unit normal output channel: valid/ready with normal and degenerate flag.
// ----------------------------------------------------------------------------
interface tun_out_if;
	logic              valid;
	logic              ready;
	tun_pkg::tri_out_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

FILE: rtl/core/tun_ratio_lane.sv
// ----------------------------------------------------------------------------
// tun_ratio_lane
// Pipelined bit-serial search of w = floor(sqrt(m^2 * 2^(2F+2) / S)), one
// root bit per stage, then rounding q = (w+1)/2 and sign/saturation.
// ----------------------------------------------------------------------------
module tun_ratio_lane (
	input  logic                              clk,
	input  logic                              en,
	input  logic [tun_pkg::SQ_W-1:0]          sq,
	input  logic [tun_pkg::SUM_W-1:0]         sum,
	input  logic                              neg,
	output logic signed [tun_pkg::NORM_W-1:0] comp
);
	import tun_pkg::*;

	logic [RW-1:0]     r_s [0:ROOT_W];
	logic [RW-1:0]     p_s [0:ROOT_W];
	logic [RW-1:0]     sm_s [0:ROOT_W];
	logic [ROOT_W-1:0] x_s [0:ROOT_W];
	logic              neg_s [0:ROOT_W];

	// remainder R = T - x^2 S, partial product P = x S
	assign r_s[0]   = RW'(sq) << SCALE_SH;
	assign p_s[0]   = '0;
	assign sm_s[0]  = RW'(sum);
	assign x_s[0]   = '0;
	assign neg_s[0] = neg;

	for (genvar i = 0; i < ROOT_W; i++) begin : g_step
		localparam int K = ROOT_W - 1 - i;
		logic [RW-1:0] d;
		logic          take;

		assign d    = (p_s[i] << (K + 1)) + (sm_s[i] << (2 * K));
		assign take = d <= r_s[i];

		always_ff @(posedge clk) begin
			if (en) begin
				r_s[i+1]   <= take ? r_s[i] - d : r_s[i];
				p_s[i+1]   <= take ? p_s[i] + (sm_s[i] << K) : p_s[i];
				x_s[i+1]   <= x_s[i] | (ROOT_W'(take) << K);
				sm_s[i+1]  <= sm_s[i];
				neg_s[i+1] <= neg_s[i];
			end
		end
	end

	logic [ROOT_W-1:0] q_full;
	logic [NORM_W-1:0] q;

	assign q_full = (x_s[ROOT_W] + ROOT_W'(1)) >> 1;
	assign q      = q_full[NORM_W-1:0];

	always_comb begin
		if (neg_s[ROOT_W])
			comp = -$signed(q);
		else if (q[NORM_W-1])
			comp = $signed({1'b0, {(NORM_W-1){1'b1}}});
		else
			comp = $signed(q);
	end

endmodule

FILE: rtl/core/triangle_unit_normal_core.sv
// ----------------------------------------------------------------------------
// triangle_unit_normal_core
// Pipeline: 5 front stages, 17 root-search stages, one output register.
// Throughput: one triangle per cycle; the whole pipe advances together and
// holds while the output stalls.
// Reset clears all valid bits; the datapath registers are not reset.
// ----------------------------------------------------------------------------
module triangle_unit_normal_core (
	input  logic        clk,
	input  logic        arst_n,
	tun_in_if.sink      in_ch,
	tun_out_if.source   out_ch
);
	import tun_pkg::*;

	logic en;
	assign en          = !out_ch.valid || out_ch.ready;
	assign in_ch.ready = en;

	// stage 1: edges
	logic signed [EDGE_W-1:0] e0_s1 [0:2];
	logic signed [EDGE_W-1:0] e1_s1 [0:2];
	// stage 2: products
	logic signed [PROD_W-1:0] pa_s2 [0:2];
	logic signed [PROD_W-1:0] pb_s2 [0:2];
	// stage 3: cross product as sign/magnitude
	logic [MAG_W-1:0]         mag_s3 [0:2];
	logic                     neg_s3 [0:2];
	// stage 4: squares
	logic [SQ_W-1:0]          sq_s4 [0:2];
	logic                     neg_s4 [0:2];
	// stage 5: sum of squares
	logic [SQ_W-1:0]          sq_s5 [0:2];
	logic                     neg_s5 [0:2];
	logic [SUM_W-1:0]         sum_s5;

	logic v_s1, v_s2, v_s3, v_s4, v_s5;
	logic vl_s [1:ROOT_W];
	logic dg_s [1:ROOT_W];

	tri_in_t d;
	assign d = in_ch.data;

	always_ff @(posedge clk) begin
		if (en) begin
			e0_s1[0] <= EDGE_W'(d.second_x) - EDGE_W'(d.first_x);
			e0_s1[1] <= EDGE_W'(d.second_y) - EDGE_W'(d.first_y);
			e0_s1[2] <= EDGE_W'(d.second_z) - EDGE_W'(d.first_z);
			e1_s1[0] <= EDGE_W'(d.third_x) - EDGE_W'(d.first_x);
			e1_s1[1] <= EDGE_W'(d.third_y) - EDGE_W'(d.first_y);
			e1_s1[2] <= EDGE_W'(d.third_z) - EDGE_W'(d.first_z);

			pa_s2[0] <= PROD_W'(e0_s1[1]) * PROD_W'(e1_s1[2]);
			pb_s2[0] <= PROD_W'(e0_s1[2]) * PROD_W'(e1_s1[1]);
			pa_s2[1] <= PROD_W'(e0_s1[2]) * PROD_W'(e1_s1[0]);
			pb_s2[1] <= PROD_W'(e0_s1[0]) * PROD_W'(e1_s1[2]);
			pa_s2[2] <= PROD_W'(e0_s1[0]) * PROD_W'(e1_s1[1]);
			pb_s2[2] <= PROD_W'(e0_s1[1]) * PROD_W'(e1_s1[0]);
		end
	end

	for (genvar i = 0; i < 3; i++) begin : g_comp
		logic signed [CROSS_W-1:0] c;
		logic [CROSS_W-1:0]        cabs;

		assign c    = CROSS_W'(pa_s2[i]) - CROSS_W'(pb_s2[i]);
		assign cabs = c[CROSS_W-1] ? CROSS_W'(-c) : CROSS_W'(c);

		always_ff @(posedge clk) begin
			if (en) begin
				mag_s3[i] <= cabs[MAG_W-1:0];
				neg_s3[i] <= c[CROSS_W-1];
				sq_s4[i]  <= SQ_W'(mag_s3[i]) * SQ_W'(mag_s3[i]);
				neg_s4[i] <= neg_s3[i];
				sq_s5[i]  <= sq_s4[i];
				neg_s5[i] <= neg_s4[i];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en)
			sum_s5 <= SUM_W'(sq_s4[0]) + SUM_W'(sq_s4[1]) + SUM_W'(sq_s4[2]);
	end

	logic signed [NORM_W-1:0] comp [0:2];

	for (genvar i = 0; i < 3; i++) begin : g_lane
		tun_ratio_lane u_lane (
			.clk  (clk),
			.en   (en),
			.sq   (sq_s5[i]),
			.sum  (sum_s5),
			.neg  (neg_s5[i]),
			.comp (comp[i])
		);
	end

	// degenerate flag rides alongside the search stages
	always_ff @(posedge clk) begin
		if (en) begin
			dg_s[1] <= sum_s5 == '0;
			for (int i = 2; i <= ROOT_W; i++)
				dg_s[i] <= dg_s[i-1];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
			for (int i = 1; i <= ROOT_W; i++)
				vl_s[i] <= 1'b0;
			out_ch.valid <= 1'b0;
		end else if (en) begin
			v_s1    <= in_ch.valid;
			v_s2    <= v_s1;
			v_s3    <= v_s2;
			v_s4    <= v_s3;
			v_s5    <= v_s4;
			vl_s[1] <= v_s5;
			for (int i = 2; i <= ROOT_W; i++)
				vl_s[i] <= vl_s[i-1];
			out_ch.valid <= vl_s[ROOT_W];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			if (dg_s[ROOT_W]) begin
				out_ch.data.normal_x <= '0;
				out_ch.data.normal_y <= '0;
				out_ch.data.normal_z <= '0;
			end else begin
				out_ch.data.normal_x <= comp[0];
				out_ch.data.normal_y <= comp[1];
				out_ch.data.normal_z <= comp[2];
			end
			out_ch.data.degenerate <= dg_s[ROOT_W];
		end
	end

endmodule

FILE: tb/tun_checker.sv
// ----------------------------------------------------------------------------
// tun_checker
// Watches both channels of the triangle unit normal core. Each input
// transaction is turned into an expected unit normal by an exact integer
// model: cross product at full width, then a root search for each component.
// Output transactions are compared field by field in order.
// ----------------------------------------------------------------------------
module tun_checker
	import tun_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	tun_in_if    in_ch,
	tun_out_if   out_ch,
	output int   errors,
	output int   pending
);

	tri_out_t normal_q[$];

	// nearest integer to mag * 2^15 / sqrt(sum), ties away from zero
	function automatic logic [16:0] scaled_component(logic [35:0] mag, logic [127:0] sum);
		logic [127:0] rhs;
		logic [127:0] lhs;
		logic [127:0] odd;
		int unsigned  lo;
		int unsigned  hi;
		int unsigned  mid;
		rhs = {92'd0, mag} * {92'd0, mag};
		rhs = rhs << (2 * FRAC_W + 2);
		lo = 0;
		hi = 1 << FRAC_W;
		while (lo < hi) begin
			mid = lo + (hi - lo + 1) / 2;
			odd = 2 * mid - 1;
			lhs = odd * odd * sum;
			if (lhs <= rhs)
				lo = mid;
			else
				hi = mid - 1;
		end
		return lo[16:0];
	endfunction

	function automatic tri_out_t predict_normal(tri_in_t t);
		logic signed [17:0] e0 [3];
		logic signed [17:0] e1 [3];
		logic signed [36:0] cr [3];
		logic [35:0]        mag [3];
		logic [127:0]       sum;
		logic [16:0]        q;
		logic [NORM_W-1:0]  comp [3];
		tri_out_t           r;
		e0[0] = t.second_x - t.first_x;
		e0[1] = t.second_y - t.first_y;
		e0[2] = t.second_z - t.first_z;
		e1[0] = t.third_x - t.first_x;
		e1[1] = t.third_y - t.first_y;
		e1[2] = t.third_z - t.first_z;
		cr[0] = e0[1] * e1[2] - e0[2] * e1[1];
		cr[1] = e0[2] * e1[0] - e0[0] * e1[2];
		cr[2] = e0[0] * e1[1] - e0[1] * e1[0];
		sum = '0;
		for (int i = 0; i < 3; i++) begin
			mag[i] = cr[i] < 0 ? 36'(-cr[i]) : 36'(cr[i]);
			sum += {92'd0, mag[i]} * {92'd0, mag[i]};
		end
		r = '0;
		if (sum == 0) begin
			r.degenerate = 1'b1;
			return r;
		end
		for (int i = 0; i < 3; i++) begin
			q = scaled_component(mag[i], sum);
			if (cr[i] < 0)
				comp[i] = NORM_W'(-q);
			else if (q >= (1 << FRAC_W))
				comp[i] = NORM_W'((1 << FRAC_W) - 1);
			else
				comp[i] = q[NORM_W-1:0];
		end
		r.normal_x = comp[0];
		r.normal_y = comp[1];
		r.normal_z = comp[2];
		return r;
	endfunction

	task automatic report(string field, longint want, longint got);
		$display("mismatch %s: expected %0d got %0d at %0t", field, want, got, $realtime);
		errors++;
	endtask

	initial errors = 0;

	assign pending = normal_q.size();

	always @(posedge clk) begin
		tri_out_t want;
		tri_out_t got;
		if (arst_n) begin
			if (in_ch.valid && in_ch.ready)
				normal_q.push_back(predict_normal(in_ch.data));
			if (out_ch.valid && out_ch.ready) begin
				got = out_ch.data;
				if (normal_q.size() == 0) begin
					$display("unexpected output transaction at %0t", $realtime);
					errors++;
				end else begin
					want = normal_q.pop_front();
					if (got.normal_x !== want.normal_x)
						report("normal_x", want.normal_x, got.normal_x);
					if (got.normal_y !== want.normal_y)
						report("normal_y", want.normal_y, got.normal_y);
					if (got.normal_z !== want.normal_z)
						report("normal_z", want.normal_z, got.normal_z);
					if (got.degenerate !== want.degenerate)
						report("degenerate", want.degenerate, got.degenerate);
				end
			end
		end
	end

endmodule

FILE: tb/tb_triangle_unit_normal_core.sv
// ----------------------------------------------------------------------------
// tb_triangle_unit_normal_core
// Drives triangles into the unit normal core: a directed set of axis-aligned,
// degenerate and extreme triangles, then random ones, with random gaps on the
// input and random stalls on the output. The checker judges every result.
// ----------------------------------------------------------------------------
module tb_triangle_unit_normal_core;
	import tun_pkg::*;

	localparam int RANDOM_TRIS = 1450;
	localparam int CYCLE_LIMIT = 400000;

	logic clk;
	logic arst_n;
	int   errors;
	int   pending;
	int   cycles;
	bit   in_burst;
	bit   out_burst;

	tun_in_if  in_ch ();
	tun_out_if out_ch ();

	triangle_unit_normal_core u_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.in_ch  (in_ch.sink),
		.out_ch (out_ch.source)
	);

	tun_checker u_checker (
		.clk     (clk),
		.arst_n  (arst_n),
		.in_ch   (in_ch),
		.out_ch  (out_ch),
		.errors  (errors),
		.pending (pending)
	);

	initial clk = 1'b0;
	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles >= CYCLE_LIMIT) begin
			$display("FAIL triangle_unit_normal_core");
			$finish;
		end
	end

	function automatic tri_in_t make_tri(int ax, int ay, int az, int bx, int by, int bz,
			int cx, int cy, int cz);
		tri_in_t t;
		t.first_x  = 16'(ax);
		t.first_y  = 16'(ay);
		t.first_z  = 16'(az);
		t.second_x = 16'(bx);
		t.second_y = 16'(by);
		t.second_z = 16'(bz);
		t.third_x  = 16'(cx);
		t.third_y  = 16'(cy);
		t.third_z  = 16'(cz);
		return t;
	endfunction

	function automatic int corner_value();
		case ($urandom_range(0, 3))
			0: return -32768;
			1: return 32767;
			2: return 0;
			default: return -1;
		endcase
	endfunction

	function automatic tri_in_t random_tri();
		tri_in_t      t;
		int           bx, by, bz, dx, dy, dz, k;
		logic [159:0] raw;
		case ($urandom_range(0, 19))
			0, 1, 2: begin
				// small triangle around a random point
				bx = $urandom_range(0, 65535) - 32768;
				by = $urandom_range(0, 65535) - 32768;
				bz = $urandom_range(0, 65535) - 32768;
				t = make_tri(bx, by, bz,
					bx + $urandom_range(0, 64) - 32, by + $urandom_range(0, 64) - 32,
					bz + $urandom_range(0, 64) - 32,
					bx + $urandom_range(0, 64) - 32, by + $urandom_range(0, 64) - 32,
					bz + $urandom_range(0, 64) - 32);
			end
			3, 4: begin
				// collinear: third vertex on the line through the first two
				bx = $urandom_range(0, 2000) - 1000;
				by = $urandom_range(0, 2000) - 1000;
				bz = $urandom_range(0, 2000) - 1000;
				dx = $urandom_range(0, 200) - 100;
				dy = $urandom_range(0, 200) - 100;
				dz = $urandom_range(0, 200) - 100;
				k = $urandom_range(0, 20) - 10;
				t = make_tri(bx, by, bz, bx + dx, by + dy, bz + dz,
					bx + k * dx, by + k * dy, bz + k * dz);
			end
			5:
				t = make_tri(corner_value(), corner_value(), corner_value(),
					corner_value(), corner_value(), corner_value(),
					corner_value(), corner_value(), corner_value());
			default: begin
				raw = {$urandom(), $urandom(), $urandom(), $urandom(), $urandom()};
				t = raw[$bits(tri_in_t)-1:0];
			end
		endcase
		return t;
	endfunction

	task automatic send_tri(tri_in_t t);
		int gap;
		gap = in_burst ? 0 : $urandom_range(0, 19);
		if (gap > 0) begin
			in_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_ch.valid <= 1'b1;
		in_ch.data  <= t;
		do @(posedge clk); while (!in_ch.ready);
	endtask

	// output side: random stall before each transaction
	always begin
		int stall;
		if (arst_n !== 1'b1) begin
			@(posedge clk);
		end else begin
			stall = out_burst ? 0 : $urandom_range(0, 19);
			if (stall > 0) begin
				out_ch.ready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			out_ch.ready <= 1'b1;
			do @(posedge clk); while (!out_ch.valid);
		end
	end

	initial begin
		tri_in_t directed [$];
		int      drain;
		cycles       = 0;
		in_burst     = 1'b0;
		out_burst    = 1'b0;
		arst_n       = 1'b0;
		in_ch.valid  = 1'b0;
		in_ch.data   = '0;
		out_ch.ready = 1'b0;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		directed.push_back(make_tri(0, 0, 0, 0, 0, 0, 0, 0, 0));
		directed.push_back(make_tri(100, -200, 300, 100, -200, 300, 100, -200, 300));
		directed.push_back(make_tri(0, 0, 0, 16, 16, 16, 32, 32, 32));
		// axis-aligned: components hit +1 (saturated) and -1
		directed.push_back(make_tri(0, 0, 0, 16, 0, 0, 0, 16, 0));
		directed.push_back(make_tri(0, 0, 0, 0, 16, 0, 16, 0, 0));
		directed.push_back(make_tri(0, 0, 0, 0, 16, 0, 0, 0, 16));
		directed.push_back(make_tri(0, 0, 0, 0, 0, 16, 0, 16, 0));
		directed.push_back(make_tri(0, 0, 0, 0, 0, 16, 16, 0, 0));
		directed.push_back(make_tri(0, 0, 0, 16, 0, 0, 0, 0, 16));
		directed.push_back(make_tri(16, 0, 0, 0, 16, 0, 0, 0, 16));
		directed.push_back(make_tri(0, 0, 0, 1, 0, 0, 0, 1, 0));
		// largest edges
		directed.push_back(make_tri(-32768, -32768, -32768, 32767, -32768, -32768,
			-32768, 32767, -32768));
		directed.push_back(make_tri(32767, 32767, 32767, -32768, 32767, 32767,
			32767, -32768, 32767));
		directed.push_back(make_tri(-32768, 32767, -32768, 32767, -32768, 32767,
			32767, 32767, -32768));
		directed.push_back(make_tri(-32768, -32768, -32768, 32767, 32767, 32767,
			-32768, 32767, 32767));
		directed.push_back(make_tri(-32768, -32768, -32768, 32767, 32767, 32767,
			32767, 32767, 32767));
		directed.push_back(make_tri(-1, -1, -1, 0, 0, 0, 3, 5, 7));
		for (int i = 0; i < 6; i++)
			directed.push_back(make_tri(corner_value(), corner_value(), corner_value(),
				corner_value(), corner_value(), corner_value(),
				corner_value(), corner_value(), corner_value()));

		foreach (directed[i])
			send_tri(directed[i]);
		for (int i = 0; i < RANDOM_TRIS; i++) begin
			if (i % 100 == 0) begin
				in_burst  = ($urandom_range(0, 3) == 0);
				out_burst = ($urandom_range(0, 3) == 0);
			end
			send_tri(random_tri());
		end
		in_ch.valid <= 1'b0;

		// let the checker record the last input transaction first
		@(posedge clk);
		while (pending != 0)
			@(posedge clk);
		drain = 0;
		while (drain < 30) begin
			@(posedge clk);
			drain++;
		end
		if (errors == 0)
			$display("PASS triangle_unit_normal_core");
		else
			$display("FAIL triangle_unit_normal_core");
		$finish;
	end

endmodule
